### hdl/ngdp_pkg.sv
package ngdp_pkg;

    localparam int DIGITS = 16;
    localparam int DIG_W  = 4;
    localparam int NUM_W  = DIGITS * DIG_W;
    localparam int IDX_W  = $clog2(DIGITS);

    localparam logic [DIG_W-1:0] BCD_MAX = DIG_W'(9);

    // Result of the digit scan, handed from the scan to the assembly logic
    typedef struct packed {
        logic             bad;   // some digit above nine
        logic             hit;   // pivot found
        logic [IDX_W-1:0] piv;   // pivot position
        logic [IDX_W-1:0] sw;    // swap partner position, below the pivot
    } t_scan;

endpackage

### hdl/ngdp_scan.sv
module ngdp_scan
    import ngdp_pkg::*;
(
    input  logic [NUM_W-1:0] i_number,
    output t_scan            o_scan
);

    logic [DIGITS-1:0] w_nz;
    logic [DIGITS-1:0] w_above;
    logic [DIGITS-1:0] w_cand;
    logic [DIGITS-1:0] w_gt;
    logic [DIGITS-1:0] w_big;
    logic [IDX_W-1:0]  w_piv;
    logic [IDX_W-1:0]  w_sw;
    logic [DIG_W-1:0]  w_dp;

    genvar g;
    generate
        for (g = 0; g < DIGITS; g++) begin : g_dig
            assign w_nz[g]    = i_number[g*DIG_W +: DIG_W] != '0;
            assign w_big[g]   = i_number[g*DIG_W +: DIG_W] > BCD_MAX;
            // digit g lies inside the number when it or any higher digit is nonzero
            assign w_above[g] = |(w_nz >> g);
            if (g == 0) begin : g_low
                assign w_cand[g] = 1'b0;
            end else begin : g_up
                assign w_cand[g] = w_above[g] &&
                    (i_number[g*DIG_W +: DIG_W] < i_number[(g-1)*DIG_W +: DIG_W]);
            end
            assign w_gt[g] = (IDX_W'(g) < w_piv) && (i_number[g*DIG_W +: DIG_W] > w_dp);
        end
    endgenerate

    // lowest candidate wins
    always_comb begin
        w_piv = '0;
        for (int i = DIGITS - 1; i > 0; i--) begin
            if (w_cand[i]) begin
                w_piv = IDX_W'(i);
            end
        end
    end

    assign w_dp = i_number[w_piv*DIG_W +: DIG_W];

    // digits below the pivot rise toward it: first larger one is the smallest larger
    always_comb begin
        w_sw = '0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (w_gt[i]) begin
                w_sw = IDX_W'(i);
            end
        end
    end

    assign o_scan.bad = |w_big;
    assign o_scan.hit = |w_cand;
    assign o_scan.piv = w_piv;
    assign o_scan.sw  = w_sw;

endmodule

### hdl/ngdp_build.sv
module ngdp_build
    import ngdp_pkg::*;
(
    input  logic [NUM_W-1:0] i_number,
    input  t_scan            i_scan,
    output logic [NUM_W-1:0] o_next,
    output logic             o_found
);

    logic [DIG_W-1:0] w_dp;
    logic [DIG_W-1:0] w_ds;
    logic [NUM_W-1:0] w_built;

    assign w_dp = i_number[i_scan.piv*DIG_W +: DIG_W];
    assign w_ds = i_number[i_scan.sw*DIG_W +: DIG_W];

    // swap pivot with partner, then reverse the digits below the pivot
    always_comb begin
        logic [IDX_W-1:0] j;
        j       = '0;
        w_built = '0;
        for (int k = 0; k < DIGITS; k++) begin
            j = i_scan.piv - IDX_W'(1) - IDX_W'(k);
            if (IDX_W'(k) > i_scan.piv) begin
                w_built[k*DIG_W +: DIG_W] = i_number[k*DIG_W +: DIG_W];
            end else if (IDX_W'(k) == i_scan.piv) begin
                w_built[k*DIG_W +: DIG_W] = w_ds;
            end else if (j == i_scan.sw) begin
                w_built[k*DIG_W +: DIG_W] = w_dp;
            end else begin
                w_built[k*DIG_W +: DIG_W] = i_number[j*DIG_W +: DIG_W];
            end
        end
    end

    assign o_found = i_scan.hit && !i_scan.bad;
    assign o_next  = o_found ? w_built : '0;

endmodule

### hdl/next_greater_digit_permutation.sv
// Next greater digit permutation of a 16-digit packed BCD number. Each request
// on the slave stream carries one number (least significant digit in bits 3:0);
// the master stream returns the smallest larger number built from the same
// digits, with tuser high, or zero with tuser low when no larger arrangement
// exists, when the number has fewer than two significant digits, or when any
// digit is above nine. Leading zeros are not treated as digits. One request is
// taken every cycle while the master side does not stall; a request passes from
// the input register, where the single compare/select/reverse stage works on it,
// to the result register, which presents the result on the master side.
// Back-pressure on the master side stalls the pipe without losing or repeating
// results.
module next_greater_digit_permutation
    import ngdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [NUM_W-1:0] s_axis_tdata,   // [63:0] number_bcd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [NUM_W-1:0] m_axis_tdata,   // [63:0] next_bcd
    output logic             m_axis_tuser    // [0] found
);

    // input stage
    logic             r_in_valid;
    logic             n_in_valid;
    logic [NUM_W-1:0] r_in_num;

    // result stage
    logic             r_out_valid;
    logic             n_out_valid;
    logic [NUM_W-1:0] r_out_next;
    logic             r_out_found;

    logic             w_out_free;
    logic             w_in_adv;
    logic             w_in_take;
    t_scan            w_scan;
    logic [NUM_W-1:0] w_next;
    logic             w_found;

    // result slot frees when empty or being taken this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_adv      = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // find pivot and swap partner
    ngdp_scan u_scan (
        .i_number (r_in_num),
        .o_scan   (w_scan)
    );

    // assemble the permuted number
    ngdp_build u_build (
        .i_number (r_in_num),
        .i_scan   (w_scan),
        .o_next   (w_next),
        .o_found  (w_found)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        // refill input stage whenever it drains or is empty
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
        // advance into result stage, or hold a stalled result
        if (w_out_free) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_num <= s_axis_tdata;
        end
        if (w_in_adv) begin
            r_out_next  <= w_next;
            r_out_found <= w_found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_next;
    assign m_axis_tuser  = r_out_found;

endmodule

### hdl/ngdp_checker.sv
module ngdp_checker
    import ngdp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [NUM_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    // stalled result keeps its valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped under stall");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed under stall");

    // no larger permutation means a zero result
    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero result without found");

    // a larger permutation is never zero
    a_nonzero_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
        else $error("zero result with found");

    // an empty result slot never blocks new requests
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while result slot empty");

endmodule

bind next_greater_digit_permutation ngdp_checker u_ngdp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import ngdp_pkg::*;

    localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
    localparam int TAIL_CYCLES = 8;     // settle time after the last result
    localparam int RAND_ITEMS  = 550;
    localparam int CALM_FROM   = 450;   // random items from here on run with no stalls

    typedef struct packed {
        logic [NUM_W-1:0] next_bcd;
        logic             found;
    } t_perm;

    // Expected permutations of the accepted numbers, plus the digit logic that
    // produces them.
    class t_perm_board;
        t_perm expected_perms[$];
        int    numbers_taken;
        int    found_count;
        int    none_count;
        int    errors;

        function t_perm next_permutation(logic [NUM_W-1:0] num);
            logic [DIG_W-1:0] d [DIGITS];
            logic [DIG_W-1:0] t;
            int               len, piv, sw, i, j;
            t_perm            r;
            r   = '0;
            len = 0;
            piv = -1;
            sw  = -1;
            for (i = 0; i < DIGITS; i++) d[i] = num[i*DIG_W +: DIG_W];
            // reject any non-BCD digit; leading zeros do not count as digits
            for (i = 0; i < DIGITS; i++) begin
                if (d[i] > BCD_MAX) return r;
                if (d[i] != '0) len = i + 1;
            end
            for (i = 1; i < len; i++) begin
                if (d[i] < d[i-1]) begin
                    piv = i;
                    break;
                end
            end
            if (piv < 0) return r;
            // suffix is non-decreasing upward, so the first larger digit is the smallest
            for (i = 0; i < piv; i++) begin
                if (d[i] > d[piv]) begin
                    sw = i;
                    break;
                end
            end
            if (sw < 0) return r;
            t      = d[piv];
            d[piv] = d[sw];
            d[sw]  = t;
            for (i = 0, j = piv - 1; i < j; i++, j--) begin
                t    = d[i];
                d[i] = d[j];
                d[j] = t;
            end
            for (i = 0; i < DIGITS; i++) r.next_bcd[i*DIG_W +: DIG_W] = d[i];
            r.found = 1'b1;
            return r;
        endfunction

        function void note_number(logic [NUM_W-1:0] num);
            expected_perms.push_back(next_permutation(num));
            numbers_taken++;
        endfunction

        function int pending();
            return expected_perms.size();
        endfunction

        task report_mismatch(string what, logic [NUM_W-1:0] got, logic [NUM_W-1:0] want);
            $display("MISMATCH @%0t: %s got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [NUM_W-1:0] next_bcd, logic found);
            t_perm want;
            if (expected_perms.size() == 0) begin
                report_mismatch("result with no pending request", next_bcd, '0);
                return;
            end
            want = expected_perms.pop_front();
            if (want.found) found_count++;
            else none_count++;
            if (next_bcd !== want.next_bcd)
                report_mismatch("next_bcd", next_bcd, want.next_bcd);
            if (found !== want.found)
                report_mismatch("found", NUM_W'(found), NUM_W'(want.found));
        endtask
    endclass

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [NUM_W-1:0] s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [NUM_W-1:0] m_data;
    logic             m_user;
    bit               gaps_on = 1'b1;

    t_perm_board board = new();

    next_greater_digit_permutation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // [63:0] number_bcd
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),    // [63:0] next_bcd
        .m_axis_tuser  (m_user)     // [0] found
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offer one request; enter and leave at a falling edge. Hold the data until
    // the block takes it, sometimes after a random idle burst.
    task automatic send_number(input logic [NUM_W-1:0] num);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= num;
        do @(posedge i_clk); while (!s_ready);
        board.note_number(num);
        @(negedge i_clk);
    endtask

    // Build a random number; most are valid BCD shaped to hit pivots at
    // varying depths, some have no pivot, some carry a bad digit.
    function automatic logic [NUM_W-1:0] random_number();
        logic [DIG_W-1:0] d [DIGITS];
        logic [DIG_W-1:0] a, b, t;
        logic [NUM_W-1:0] v;
        int               kind, len, k, i, j;
        kind = $urandom_range(0, 99);
        if (kind >= 95) return {$urandom, $urandom};
        len = $urandom_range(1, DIGITS);
        a   = DIG_W'($urandom_range(0, 9));
        b   = DIG_W'($urandom_range(0, 9));
        for (i = 0; i < DIGITS; i++) begin
            if (i >= len) d[i] = '0;
            else if (kind < 20) d[i] = $urandom_range(0, 1) ? a : b;  // many repeats
            else d[i] = DIG_W'($urandom_range(0, 9));
        end
        // sort the low digits ascending upward: no pivot inside them
        k = 0;
        if (kind >= 20 && kind < 60) k = $urandom_range(1, len);
        else if (kind >= 60 && kind < 70) k = len;
        for (i = 0; i < k; i++) begin
            for (j = 0; j + 1 < k - i; j++) begin
                if (d[j] > d[j+1]) begin
                    t      = d[j];
                    d[j]   = d[j+1];
                    d[j+1] = t;
                end
            end
        end
        if (kind >= 90) d[$urandom_range(0, DIGITS-1)] = DIG_W'($urandom_range(10, 15));
        for (i = 0; i < DIGITS; i++) v[i*DIG_W +: DIG_W] = d[i];
        return v;
    endfunction

    // Sink side: drop ready in random bursts while stalls are enabled.
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (gaps_on && i_rst_n && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) board.check_result(m_data, m_user);
    end

    // Abort if the streams stop moving.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial begin : main
        int n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, no-pivot shapes, equal swap candidates, bad digits
        send_number(64'h0);
        send_number(64'h1);
        send_number(64'h9);
        send_number(64'h12);
        send_number(64'h21);
        send_number(64'h10);
        send_number(64'h90);
        send_number(64'h531);
        send_number(64'h777);
        send_number(64'h115);
        send_number(64'h1223);
        send_number(64'h1022);
        send_number(64'h9876543210);
        send_number(64'h1234567890123456);
        send_number(64'h8999999999999999);
        send_number(64'h1999999999999998);
        send_number(64'h9999999999999999);
        send_number(64'h1000000000000000);
        send_number(64'h0123456789ABCDEF);
        send_number(64'h9A);
        send_number(64'hF000000000000012);
        send_number(64'hFFFFFFFFFFFFFFFF);

        // random: stalls on most stretches, back-to-back at the end
        for (n = 0; n < RAND_ITEMS; n++) begin
            gaps_on = (n < CALM_FROM) && ((n % 150) < 110);
            send_number(random_number());
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d numbers: %0d had a larger permutation, %0d had none",
                 board.numbers_taken, board.found_count, board.none_count);
        $display("traffic: directed corners, random BCD with stalls, then a no-stall burst");
        if (board.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
